// ----- sv/snt_pkg.sv -----
// Shared types and codes for the score note tracker.
// No dependencies; score_note_tracker_core imports it.
package snt_pkg;

  // Item kinds
  localparam logic [1:0] KIND_LOAD   = 2'd0;
  localparam logic [1:0] KIND_REPOS  = 2'd1;
  localparam logic [1:0] KIND_PLAYED = 2'd2;

  // Result codes
  localparam logic [2:0] ST_MATCHED        = 3'd0;
  localparam logic [2:0] ST_NO_MATCH       = 3'd1;
  localparam logic [2:0] ST_NOT_POSITIONED = 3'd2;
  localparam logic [2:0] ST_IGNORED        = 3'd3;
  localparam logic [2:0] ST_REPOS_FAILED   = 3'd4;
  localparam logic [2:0] ST_DONE           = 3'd5;

  // Configuration register indexes
  localparam logic REG_LOCATION_COUNT = 1'b0;
  localparam logic REG_SEARCH_SPAN    = 1'b1;

  localparam logic [4:0] SPAN_AT_RESET = 5'd3;

  // One note slot as kept in a location word
  typedef struct packed {
    logic        valid;
    logic        matched;
    logic [6:0]  pitch;
    logic [15:0] score_event;
  } snt_slot_t;

  localparam int SLOT_BITS = $bits(snt_slot_t);

endpackage

// ----- sv/snt_if.sv -----
// Channel interfaces of the score note tracker: input items and results.
// Depends on nothing but the handshake convention (valid, ready).
interface snt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [9:0]  location;
  logic [2:0]  slot;
  logic [6:0]  pitch;
  logic [15:0] score_event;
  logic        is_note_on;

  modport source (output valid, kind, location, slot, pitch, score_event, is_note_on,
                  input ready);
  modport sink (input valid, kind, location, slot, pitch, score_event, is_note_on,
                output ready);
endinterface

interface snt_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [9:0] score_location;

  modport source (output valid, status, score_location, input ready);
  modport sink (input valid, status, score_location, output ready);
endinterface

// ----- sv/snt_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module snt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write, and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- sv/score_note_tracker_core.sv -----
// Score note tracker: one location word per score location in a single RAM,
// read, modified and written back by a sequencer. Uses snt_pkg, snt_if, snt_ram.
//
// Channels: in_ch takes one item per beat (load slot, reposition, performed
// event); out_ch returns exactly one result beat per item (status, location).
// cfg_wr_en/cfg_index/cfg_wr_data write location_count (0) and search_span (1).
// One item is worked on at a time; in_ch.ready is high when the sequencer is free.
// Steps from accept to result in the output register:
//   load: a read, then a write-back with the slot filled; ignored or
//   not-positioned items: straight to the result; note-on: a read per probed
//   location inside the table (a write-back on a hit), no read for one outside,
//   at most 2*span-1 probes (span 3: at most 5); reposition: the walk over all
//   MAX_LOCATIONS location words (one RAM read a cycle, matched marks cleared on the way back).
// The output register holds a result while the receiver stalls; the next item
// is taken meanwhile, and its result waits in the sequencer until the
// register frees up.
// Reset: synchronous; afterward a clearing pass writes every location word to
// zero, one per cycle, with in_ch.ready low. Configuration writes are taken
// during the pass.
module score_note_tracker_core #(
  parameter int MAX_LOCATIONS      = 1024,
  parameter int SLOTS_PER_LOCATION = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [10:0] cfg_wr_data,
  snt_in_if.sink      in_ch,
  snt_out_if.source   out_ch
);
  import snt_pkg::*;

  localparam int LOC_W  = $clog2(MAX_LOCATIONS);
  localparam int CNT_W  = LOC_W + 1;
  localparam int SL_W   = (SLOTS_PER_LOCATION > 1) ? $clog2(SLOTS_PER_LOCATION) : 1;
  localparam int WORD_W = SLOTS_PER_LOCATION * SLOT_BITS;
  localparam int PW     = ((LOC_W > 5) ? LOC_W : 5) + 2;

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_LD_A  = 3'd2;
  localparam logic [2:0] S_LD_D  = 3'd3;
  localparam logic [2:0] S_REP   = 3'd4;
  localparam logic [2:0] S_PR_A  = 3'd5;
  localparam logic [2:0] S_PR_D  = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0]  state;
  logic [10:0] location_count;
  logic [4:0]  search_span;
  logic [LOC_W-1:0] cur;
  logic        positioned;

  // latched item
  logic [LOC_W-1:0] it_loc;
  logic [SL_W-1:0]  it_slot;
  logic [6:0]       it_pitch;
  logic [15:0]      it_ev;

  logic [CNT_W-1:0] walk_addr;
  logic             rep_pend;
  logic             rep_found;
  logic [LOC_W-1:0] row_q;
  logic [4:0]       off;
  logic             dir;

  logic [2:0] res_status;
  logic [9:0] res_loc;
  logic       out_valid;
  logic [2:0] out_status;
  logic [9:0] out_loc;

  logic                ram_we, ram_re;
  logic [LOC_W-1:0]    ram_waddr, ram_raddr;
  logic [WORD_W-1:0]   ram_wdata, ram_rdata;
  snt_slot_t [SLOTS_PER_LOCATION-1:0] rd_word, ld_word, clr_word, mark_word;

  logic [CNT_W-1:0]    used;
  logic                walk_more;
  logic signed [PW-1:0] cur_ext, off_ext, probe_loc;
  logic                probe_ok;
  logic                hit;
  logic [SL_W-1:0]     hit_slot;
  logic                any_valid, any_le;
  logic [4:0]          eff_span, nx_off;
  logic                nx_dir, exhausted;
  logic                in_load_ok;

  snt_ram #(.WIDTH(WORD_W), .DEPTH(MAX_LOCATIONS)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign rd_word = ram_rdata;

  // Effective location count, clamped to the table size
  always_comb begin
    if (32'(location_count) > 32'(MAX_LOCATIONS)) begin
      used = CNT_W'(MAX_LOCATIONS);
    end else begin
      used = CNT_W'(location_count);
    end
  end

  assign walk_more = (walk_addr != CNT_W'(MAX_LOCATIONS));
  assign in_load_ok = (32'(in_ch.location) < 32'(MAX_LOCATIONS)) &&
                      (32'(in_ch.slot) < 32'(SLOTS_PER_LOCATION));

  // Probe location: current location plus or minus the offset
  assign cur_ext   = $signed(PW'(cur));
  assign off_ext   = $signed(PW'(off));
  assign probe_loc = dir ? (cur_ext - off_ext) : (cur_ext + off_ext);
  assign probe_ok  = !probe_loc[PW-1] && (probe_loc < $signed(PW'(used)));

  // Next probe in the order +1, -1, +2, -2 ...
  always_comb begin
    eff_span = (search_span == 5'd0) ? 5'd1 : search_span;
    if (off == 5'd0) begin
      nx_off = 5'd1;
      nx_dir = 1'b0;
    end else if (!dir) begin
      nx_off = off;
      nx_dir = 1'b1;
    end else begin
      nx_off = off + 5'd1;
      nx_dir = 1'b0;
    end
    exhausted = (nx_off >= eff_span);
  end

  // Word updates and slot searches
  always_comb begin
    ld_word   = rd_word;
    clr_word  = rd_word;
    mark_word = rd_word;
    hit       = 1'b0;
    hit_slot  = '0;
    any_valid = 1'b0;
    any_le    = 1'b0;
    ld_word[it_slot] = '{valid: 1'b1, matched: 1'b0, pitch: it_pitch, score_event: it_ev};
    for (int s = 0; s < SLOTS_PER_LOCATION; s++) begin
      clr_word[s].matched = 1'b0;
      if (rd_word[s].valid) begin
        any_valid = 1'b1;
        if (rd_word[s].score_event <= it_ev) begin
          any_le = 1'b1;
        end
      end
      if (!hit && rd_word[s].valid && !rd_word[s].matched && rd_word[s].pitch == it_pitch) begin
        hit      = 1'b1;
        hit_slot = SL_W'(s);
      end
    end
    mark_word[hit_slot].matched = 1'b1;
  end

  // RAM port control
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = '0;
    ram_wdata = '0;
    ram_re    = 1'b0;
    ram_raddr = '0;
    unique case (state)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = walk_addr[LOC_W-1:0];
      end
      S_LD_A: begin
        ram_re    = 1'b1;
        ram_raddr = it_loc;
      end
      S_LD_D: begin
        ram_we    = 1'b1;
        ram_waddr = it_loc;
        ram_wdata = ld_word;
      end
      S_REP: begin
        ram_re    = walk_more;
        ram_raddr = walk_addr[LOC_W-1:0];
        ram_we    = rep_pend;
        ram_waddr = row_q;
        ram_wdata = clr_word;
      end
      S_PR_A: begin
        ram_re    = probe_ok;
        ram_raddr = probe_loc[LOC_W-1:0];
      end
      S_PR_D: begin
        ram_we    = hit;
        ram_waddr = row_q;
        ram_wdata = mark_word;
      end
      default: begin
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      location_count <= '0;
      search_span    <= SPAN_AT_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_LOCATION_COUNT: location_count <= cfg_wr_data;
        REG_SEARCH_SPAN:    search_span    <= cfg_wr_data[4:0];
        default: begin
        end
      endcase
    end
  end

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLR;
      walk_addr  <= '0;
      cur        <= '0;
      positioned <= 1'b0;
      rep_pend   <= 1'b0;
      rep_found  <= 1'b0;
      off        <= '0;
      dir        <= 1'b0;
    end else begin
      unique case (state)
        S_CLR: begin
          walk_addr <= walk_addr + CNT_W'(1);
          if (walk_addr == CNT_W'(MAX_LOCATIONS - 1)) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_ch.valid) begin
            it_loc     <= LOC_W'(in_ch.location);
            it_slot    <= SL_W'(in_ch.slot);
            it_pitch   <= in_ch.pitch;
            it_ev      <= in_ch.score_event;
            res_status <= ST_IGNORED;
            res_loc    <= '0;
            state      <= S_FIN;
            priority if (in_ch.kind == KIND_LOAD) begin
              if (in_load_ok) begin
                state <= S_LD_A;
              end
            end else if (in_ch.kind == KIND_REPOS) begin
              walk_addr <= '0;
              rep_pend  <= 1'b0;
              rep_found <= 1'b0;
              state     <= S_REP;
            end else if (in_ch.kind == KIND_PLAYED && in_ch.is_note_on) begin
              if (!positioned) begin
                res_status <= ST_NOT_POSITIONED;
              end else begin
                off   <= '0;
                dir   <= 1'b0;
                state <= S_PR_A;
              end
            end
          end
        end
        S_LD_A: begin
          state <= S_LD_D;
        end
        S_LD_D: begin
          res_status <= ST_DONE;
          state      <= S_FIN;
        end
        S_REP: begin
          // advance the read side of the walk
          if (walk_more) begin
            walk_addr <= walk_addr + CNT_W'(1);
          end
          rep_pend <= walk_more;
          row_q    <= walk_addr[LOC_W-1:0];
          // evaluate the word read last cycle
          if (rep_pend && (CNT_W'(row_q) < used) && any_valid && (!rep_found || any_le)) begin
            cur       <= row_q;
            rep_found <= 1'b1;
          end
          if (!walk_more && !rep_pend) begin
            positioned <= rep_found;
            if (rep_found) begin
              res_status <= ST_DONE;
              res_loc    <= 10'(cur);
            end else begin
              cur        <= '0;
              res_status <= ST_REPOS_FAILED;
            end
            state <= S_FIN;
          end
        end
        S_PR_A: begin
          row_q <= probe_loc[LOC_W-1:0];
          if (probe_ok) begin
            state <= S_PR_D;
          end else if (exhausted) begin
            res_status <= ST_NO_MATCH;
            state      <= S_FIN;
          end else begin
            off <= nx_off;
            dir <= nx_dir;
          end
        end
        S_PR_D: begin
          if (hit) begin
            res_status <= ST_MATCHED;
            res_loc    <= 10'(row_q);
            if (!dir && off != 5'd0) begin
              cur <= row_q;
            end
            state <= S_FIN;
          end else if (exhausted) begin
            res_status <= ST_NO_MATCH;
            state      <= S_FIN;
          end else begin
            off   <= nx_off;
            dir   <= nx_dir;
            state <= S_PR_A;
          end
        end
        S_FIN: begin
          if (!out_valid || out_ch.ready) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Output register: load from the sequencer, drop on a taken beat
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == S_FIN && (!out_valid || out_ch.ready)) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_FIN && (!out_valid || out_ch.ready)) begin
      out_status <= res_status;
      out_loc    <= res_loc;
    end
  end

  assign in_ch.ready           = (state == S_IDLE);
  assign out_ch.valid          = out_valid;
  assign out_ch.status         = out_status;
  assign out_ch.score_location = out_loc;

endmodule
